@@ hw/rtl/bhpq_pkg.sv @@
package bhpq_pkg;

    localparam int HEAP_DEPTH_DEFAULT = 255;
    localparam int KEY_WIDTH_DEFAULT  = 16;
    localparam int OCC_WIDTH          = 8;
    localparam int STATUS_WIDTH       = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        RD_POS,
        RD_ROOT,
        RD_COUNT,
        RD_PARENT,
        RD_LEFT,
        RD_RIGHT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_KEY,
        WR_RDATA,
        WR_PICK
    } wr_sel_t;

    typedef enum logic [1:0] {
        POS_HOLD,
        POS_PARENT,
        POS_LEFT,
        POS_PICK
    } pos_sel_t;

    typedef struct packed {
        logic     load_item;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        pos_sel_t pos_sel;
        logic     cap_top;
        logic     cap_key;
        logic     cap_left;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_root;
        logic left_beyond;
        logic left_last;
        logic ins_move;
        logic left_move;
        logic pick_move;
    } stat_t;

endpackage

@@ hw/rtl/binary_heap_priority_queue_top.sv @@
// Priority queue held as a 1-based binary heap in a single-port-read memory with a
// registered read. Each request is an insert (opcode 0) or a remove-top (opcode 1) and
// returns exactly one result with status, occupancy and, for a remove, the top key.
// order_mode (written on the cfg channel; the user must write it only while idle, which
// the block does not enforce) picks larger-first (0) or smaller-first (1). One request
// is in work at a time: an insert reads the parent and climbs the key one level per
// compare until it stops or reaches the root; a remove reads the root and then the last
// key, which sinks, reading the left and then, if present, the right child per level.
// A finished result sits in an output register, so the next request is accepted while
// it waits; a result that cannot enter that register because the previous one is still
// stalled holds the block until the previous one is taken. Rejected requests (full or
// empty) go straight from idle to the finish state.
module binary_heap_priority_queue_top
#(
    parameter int HEAP_DEPTH = bhpq_pkg::HEAP_DEPTH_DEFAULT,
    parameter int KEY_WIDTH  = bhpq_pkg::KEY_WIDTH_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              opcode,
    input  logic [KEY_WIDTH-1:0]              key,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [KEY_WIDTH-1:0]              removed_key,
    output logic                              removed_valid,
    output logic [bhpq_pkg::STATUS_WIDTH-1:0] status,
    output logic [bhpq_pkg::OCC_WIDTH-1:0]    occupancy,
    output logic                              is_empty
);

    bhpq_pkg::cmd_t  cmd;
    bhpq_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    bhpq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (opcode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bhpq_dp
    #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .KEY_WIDTH  (KEY_WIDTH)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid & cfg_ready),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .key           (key),
        .cmd           (cmd),
        .stat          (stat),
        .removed_key   (removed_key),
        .removed_valid (removed_valid),
        .status        (status),
        .occupancy     (occupancy),
        .is_empty      (is_empty)
    );

endmodule

@@ hw/rtl/bhpq_ctrl.sv @@
module bhpq_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            opcode,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  bhpq_pkg::stat_t stat,
    output bhpq_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_TEST,
        S_INS_CMP,
        S_DEL_TOP,
        S_DEL_LAST,
        S_DEL_HOLD,
        S_DEL_LEFT,
        S_DEL_RIGHT,
        S_DEL_PICK,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.rd_sel  = bhpq_pkg::RD_POS;
        cmd.wr_sel  = bhpq_pkg::WR_KEY;
        cmd.pos_sel = bhpq_pkg::POS_HOLD;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (opcode == bhpq_pkg::OP_INSERT && !stat.full)
                        state_next = S_INS_TEST;
                    else if (opcode == bhpq_pkg::OP_REMOVE && !stat.empty)
                        state_next = S_DEL_TOP;
                    else
                        state_next = S_FINISH;
                end
            end
            S_INS_TEST:
            begin
                if (stat.pos_root)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.rd_sel = bhpq_pkg::RD_PARENT;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (stat.ins_move)
                begin
                    cmd.wr_sel  = bhpq_pkg::WR_RDATA;
                    cmd.pos_sel = bhpq_pkg::POS_PARENT;
                    state_next  = S_INS_TEST;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_DEL_TOP:
            begin
                cmd.rd_sel = bhpq_pkg::RD_ROOT;
                state_next = S_DEL_LAST;
            end
            S_DEL_LAST:
            begin
                cmd.cap_top = 1'b1;
                cmd.rd_sel  = bhpq_pkg::RD_COUNT;
                state_next  = S_DEL_HOLD;
            end
            S_DEL_HOLD:
            begin
                cmd.cap_key = 1'b1;
                state_next  = S_DEL_LEFT;
            end
            S_DEL_LEFT:
            begin
                if (stat.left_beyond)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.rd_sel = bhpq_pkg::RD_LEFT;
                    state_next = S_DEL_RIGHT;
                end
            end
            S_DEL_RIGHT:
            begin
                cmd.cap_left = 1'b1;
                if (stat.left_last)
                begin
                    cmd.wr_en = 1'b1;
                    if (stat.left_move)
                    begin
                        cmd.wr_sel  = bhpq_pkg::WR_RDATA;
                        cmd.pos_sel = bhpq_pkg::POS_LEFT;
                        state_next  = S_DEL_LEFT;
                    end
                    else
                    begin
                        cmd.cnt_dec = 1'b1;
                        state_next  = S_FINISH;
                    end
                end
                else
                begin
                    cmd.rd_sel = bhpq_pkg::RD_RIGHT;
                    state_next = S_DEL_PICK;
                end
            end
            S_DEL_PICK:
            begin
                cmd.wr_en = 1'b1;
                if (stat.pick_move)
                begin
                    cmd.wr_sel  = bhpq_pkg::WR_PICK;
                    cmd.pos_sel = bhpq_pkg::POS_PICK;
                    state_next  = S_DEL_LEFT;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/bhpq_dp.sv @@
module bhpq_dp
#(
    parameter int HEAP_DEPTH = bhpq_pkg::HEAP_DEPTH_DEFAULT,
    parameter int KEY_WIDTH  = bhpq_pkg::KEY_WIDTH_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_data,
    input  logic                              opcode,
    input  logic [KEY_WIDTH-1:0]              key,
    input  bhpq_pkg::cmd_t                    cmd,
    output bhpq_pkg::stat_t                   stat,
    output logic [KEY_WIDTH-1:0]              removed_key,
    output logic                              removed_valid,
    output logic [bhpq_pkg::STATUS_WIDTH-1:0] status,
    output logic [bhpq_pkg::OCC_WIDTH-1:0]    occupancy,
    output logic                              is_empty
);

    localparam int CW = $clog2(HEAP_DEPTH + 1);

    logic [KEY_WIDTH-1:0] mem [0:HEAP_DEPTH];

    logic                     order_mode_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [CW-1:0]            pos_reg;
    logic [KEY_WIDTH-1:0]     key_reg;
    logic [KEY_WIDTH-1:0]     top_reg;
    logic [KEY_WIDTH-1:0]     left_reg;
    logic [KEY_WIDTH-1:0]     rd_data_reg;
    logic                     op_reg;
    bhpq_pkg::status_t        item_status_reg;
    bhpq_pkg::status_t        item_status_next;
    logic [KEY_WIDTH-1:0]     removed_key_reg;
    logic                     removed_valid_reg;
    bhpq_pkg::status_t        status_reg;
    logic [CW+7:0]            occ_wide;
    logic [bhpq_pkg::OCC_WIDTH-1:0] occupancy_reg;
    logic                     is_empty_reg;

    logic [CW:0]              left_w;
    logic [CW:0]              right_w;
    logic [CW:0]              count_w;
    logic [CW-1:0]            parent;
    logic [CW-1:0]            raddr;
    logic [KEY_WIDTH-1:0]     wdata;
    logic                     pick_right;
    logic [KEY_WIDTH-1:0]     pick_data;
    logic [CW-1:0]            pick_pos;
    logic                     item_ok;

    function automatic logic outranks(input logic mode, input logic [KEY_WIDTH-1:0] a,
                                      input logic [KEY_WIDTH-1:0] b);
        if (mode)
            return a < b;
        return a > b;
    endfunction

    assign left_w  = {pos_reg, 1'b0};
    assign right_w = {pos_reg, 1'b1};
    assign count_w = {1'b0, count_reg};
    assign parent  = pos_reg >> 1;

    assign pick_right = outranks(order_mode_reg, rd_data_reg, left_reg);
    assign pick_data  = pick_right ? rd_data_reg : left_reg;
    assign pick_pos   = pick_right ? right_w[CW-1:0] : left_w[CW-1:0];

    assign stat.full        = (count_reg >= CW'(HEAP_DEPTH));
    assign stat.empty       = (count_reg == '0);
    assign stat.pos_root    = (pos_reg == CW'(1));
    assign stat.left_beyond = (left_w > count_w);
    assign stat.left_last   = (left_w == count_w);
    assign stat.ins_move    = outranks(order_mode_reg, key_reg, rd_data_reg);
    assign stat.left_move   = outranks(order_mode_reg, rd_data_reg, key_reg);
    assign stat.pick_move   = outranks(order_mode_reg, pick_data, key_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            bhpq_pkg::RD_ROOT:   raddr = CW'(1);
            bhpq_pkg::RD_COUNT:  raddr = count_reg;
            bhpq_pkg::RD_PARENT: raddr = parent;
            bhpq_pkg::RD_LEFT:   raddr = left_w[CW-1:0];
            bhpq_pkg::RD_RIGHT:  raddr = right_w[CW-1:0];
            default:             raddr = pos_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            bhpq_pkg::WR_RDATA: wdata = rd_data_reg;
            bhpq_pkg::WR_PICK:  wdata = pick_data;
            default:            wdata = key_reg;
        endcase
    end

    always_comb
    begin
        item_status_next = bhpq_pkg::ST_DONE;
        if (opcode == bhpq_pkg::OP_INSERT && stat.full)
            item_status_next = bhpq_pkg::ST_FULL;
        else if (opcode == bhpq_pkg::OP_REMOVE && stat.empty)
            item_status_next = bhpq_pkg::ST_EMPTY;
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
            count_next = count_reg + CW'(1);
        else if (cmd.cnt_dec)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[pos_reg] <= wdata;
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_mode_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
                order_mode_reg <= cfg_data;
            count_reg <= count_next;
        end
    end

    assign item_ok  = (op_reg == bhpq_pkg::OP_REMOVE) && (item_status_reg == bhpq_pkg::ST_DONE);
    assign occ_wide = {8'd0, count_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg          <= opcode;
            key_reg         <= key;
            item_status_reg <= item_status_next;
            pos_reg         <= (opcode == bhpq_pkg::OP_INSERT) ? count_reg + CW'(1) : CW'(1);
        end
        else
        begin
            if (cmd.cap_key)
                key_reg <= rd_data_reg;
            case (cmd.pos_sel)
                bhpq_pkg::POS_PARENT: pos_reg <= parent;
                bhpq_pkg::POS_LEFT:   pos_reg <= left_w[CW-1:0];
                bhpq_pkg::POS_PICK:   pos_reg <= pick_pos;
                default:              pos_reg <= pos_reg;
            endcase
        end
        if (cmd.cap_top)
            top_reg <= rd_data_reg;
        if (cmd.cap_left)
            left_reg <= rd_data_reg;
        if (cmd.load_out)
        begin
            removed_valid_reg <= item_ok;
            removed_key_reg   <= item_ok ? top_reg : '0;
            status_reg        <= item_status_reg;
            occupancy_reg     <= occ_wide[bhpq_pkg::OCC_WIDTH-1:0];
            is_empty_reg      <= (count_reg == '0);
        end
    end

    assign removed_key   = removed_key_reg;
    assign removed_valid = removed_valid_reg;
    assign status        = status_reg;
    assign occupancy     = occupancy_reg;
    assign is_empty      = is_empty_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(HEAP_DEPTH))
        else $error("entry count above heap depth");

    a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (pos_reg != '0) && (pos_reg <= CW'(HEAP_DEPTH)))
        else $error("heap write outside positions 1..depth");

    a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> !cmd.cnt_dec && (count_reg < CW'(HEAP_DEPTH)))
        else $error("insert completed without room");

    a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> (count_reg != '0) && (pos_reg <= count_reg))
        else $error("remove completed on empty heap or past last entry");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.cnt_inc && !cmd.cnt_dec |=> $stable(count_reg))
        else $error("entry count changed without a completed request");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH = bhpq_pkg::HEAP_DEPTH_DEFAULT;
    localparam int KW    = bhpq_pkg::KEY_WIDTH_DEFAULT;
    localparam int OW    = bhpq_pkg::OCC_WIDTH;

    typedef struct {
        logic [KW-1:0]     removed_key;
        logic              removed_valid;
        bhpq_pkg::status_t status;
        logic [OW-1:0]     occupancy;
        logic              is_empty;
    } heap_result_t;

    class heap_scoreboard;
        logic [KW-1:0] slots [1:DEPTH];
        int unsigned   fill;
        bit            smaller_first;
        heap_result_t  awaited [$];
        int            errors;
        int            checked;
        int            removed;
        int            full_rejects;
        int            empty_rejects;

        function bit ranks_above(logic [KW-1:0] a, logic [KW-1:0] b);
            return smaller_first ? (a < b) : (a > b);
        endfunction

        function void note_request(logic op, logic [KW-1:0] k);
            heap_result_t  r;
            int unsigned   pos;
            int unsigned   up;
            int unsigned   child;
            logic [KW-1:0] last;
            r.removed_key   = '0;
            r.removed_valid = 1'b0;
            r.status        = bhpq_pkg::ST_DONE;
            if (op == bhpq_pkg::OP_INSERT) begin
                if (fill >= DEPTH) begin
                    r.status = bhpq_pkg::ST_FULL;
                    full_rejects++;
                end
                else begin
                    pos = fill + 1;
                    while (pos != 1) begin
                        up = pos / 2;
                        if (!ranks_above(k, slots[up]))
                            break;
                        slots[pos] = slots[up];
                        pos = up;
                    end
                    slots[pos] = k;
                    fill++;
                end
            end
            else if (fill == 0) begin
                r.status = bhpq_pkg::ST_EMPTY;
                empty_rejects++;
            end
            else begin
                r.removed_key   = slots[1];
                r.removed_valid = 1'b1;
                last = slots[fill];
                pos = 1;
                while (2 * pos <= fill) begin
                    child = 2 * pos;
                    if (child < fill && ranks_above(slots[child + 1], slots[child]))
                        child++;
                    if (!ranks_above(slots[child], last))
                        break;
                    slots[pos] = slots[child];
                    pos = child;
                end
                slots[pos] = last;
                fill--;
                removed++;
            end
            r.occupancy = fill[OW-1:0];
            r.is_empty  = (fill == 0);
            awaited.push_back(r);
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(heap_result_t got);
            heap_result_t w;
            checked++;
            if (awaited.size() == 0) begin
                report($sformatf("result %0d arrived with no request pending", checked));
                return;
            end
            w = awaited.pop_front();
            if (got.removed_key !== w.removed_key)
                report($sformatf("result %0d removed_key %0h, want %0h",
                                 checked, got.removed_key, w.removed_key));
            if (got.removed_valid !== w.removed_valid)
                report($sformatf("result %0d removed_valid %0b, want %0b",
                                 checked, got.removed_valid, w.removed_valid));
            if (got.status !== w.status)
                report($sformatf("result %0d status %0d, want %0d",
                                 checked, got.status, w.status));
            if (got.occupancy !== w.occupancy)
                report($sformatf("result %0d occupancy %0d, want %0d",
                                 checked, got.occupancy, w.occupancy));
            if (got.is_empty !== w.is_empty)
                report($sformatf("result %0d is_empty %0b, want %0b",
                                 checked, got.is_empty, w.is_empty));
        endtask
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic                              cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic                              opcode;
    logic [KW-1:0]                     key;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [KW-1:0]                     removed_key;
    logic                              removed_valid;
    logic [bhpq_pkg::STATUS_WIDTH-1:0] status;
    logic [OW-1:0]                     occupancy;
    logic                              is_empty;

    int gap_pct;
    int stall_pct;
    int sent;

    heap_scoreboard sb = new();

    binary_heap_priority_queue_top uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .key          (key),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .removed_key  (removed_key),
        .removed_valid(removed_valid),
        .status       (status),
        .occupancy    (occupancy),
        .is_empty     (is_empty)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(negedge clk)
    begin
        out_stall = ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin : watch
        heap_result_t got;
        if (rst_n === 1'b1) begin
            if (in_valid && !in_stall)
                sb.note_request(opcode, key);
            if (out_valid && !out_stall) begin
                got.removed_key   = removed_key;
                got.removed_valid = removed_valid;
                got.status        = bhpq_pkg::status_t'(status);
                got.occupancy     = occupancy;
                got.is_empty      = is_empty;
                sb.check_result(got);
            end
        end
    end

    function automatic logic [KW-1:0] pick_key();
        case ($urandom_range(5))
            0: return KW'($urandom_range(7));
            1: return $urandom_range(1) ? {KW{1'b1}} : {KW{1'b0}};
            default: return KW'($urandom_range((1 << KW) - 1));
        endcase
    endfunction

    task automatic send_request(logic op, logic [KW-1:0] k);
        while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            in_valid = 1'b0;
            opcode   = 1'($urandom_range(1));
            key      = pick_key();
            @(negedge clk);
        end
        in_valid = 1'b1;
        opcode   = op;
        key      = k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic write_order(bit mode);
        cfg_valid = 1'b1;
        cfg_data  = mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.smaller_first = mode;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (sb.awaited.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic random_run(int len, int ins_pct);
        repeat (len) begin
            if ($urandom_range(99) < ins_pct)
                send_request(bhpq_pkg::OP_INSERT, pick_key());
            else
                send_request(bhpq_pkg::OP_REMOVE, pick_key());
        end
    endtask

    initial
    begin
        int phase;
        int start;
        int ins_pct;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        in_valid  = 1'b0;
        opcode    = bhpq_pkg::OP_INSERT;
        key       = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(bhpq_pkg::OP_REMOVE, {KW{1'b1}});
        send_request(bhpq_pkg::OP_REMOVE, {KW{1'b0}});
        send_request(bhpq_pkg::OP_INSERT, {KW{1'b0}});
        send_request(bhpq_pkg::OP_INSERT, {KW{1'b1}});
        send_request(bhpq_pkg::OP_INSERT, 16'h8000);
        send_request(bhpq_pkg::OP_INSERT, 16'h7FFF);
        send_request(bhpq_pkg::OP_INSERT, {KW{1'b1}});
        send_request(bhpq_pkg::OP_INSERT, {KW{1'b0}});
        send_request(bhpq_pkg::OP_INSERT, 16'h0001);
        repeat (8) send_request(bhpq_pkg::OP_REMOVE, pick_key());
        drain_results();
        write_order(1'b1);
        send_request(bhpq_pkg::OP_INSERT, 16'd5);
        send_request(bhpq_pkg::OP_INSERT, 16'd3);
        send_request(bhpq_pkg::OP_INSERT, {KW{1'b1}});
        send_request(bhpq_pkg::OP_INSERT, {KW{1'b0}});
        repeat (4) send_request(bhpq_pkg::OP_REMOVE, pick_key());

        for (phase = 0; phase < 8; phase++) begin
            drain_results();
            write_order(1'(phase % 2));
            case ((phase / 2) % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 58; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 58; end
                default: begin gap_pct = 25; stall_pct = 25; end
            endcase
            start = sent;
            // fill to capacity and push past it, then drain under the other order
            if (phase == 3 || phase == 6) begin
                while (sb.fill < DEPTH)
                    send_request(bhpq_pkg::OP_INSERT, pick_key());
                repeat (3) send_request(bhpq_pkg::OP_INSERT, pick_key());
            end
            if (phase == 4 || phase == 7) begin
                while (sb.fill > 0)
                    send_request(bhpq_pkg::OP_REMOVE, pick_key());
                repeat (2) send_request(bhpq_pkg::OP_REMOVE, pick_key());
            end
            while (sent - start < 219) begin
                case ($urandom_range(3))
                    0: ins_pct = 30;
                    1: ins_pct = 50;
                    2: ins_pct = 70;
                    default: ins_pct = 90;
                endcase
                random_run($urandom_range(8, 40), ins_pct);
            end
        end

        drain_results();
        repeat (40) @(posedge clk);
        $display("Sent %0d requests in 8 phases under both orders; %0d results checked.",
                 sent, sb.checked);
        $display("Keys removed: %0d, full rejections: %0d, empty rejections: %0d, errors: %0d",
                 sb.removed, sb.full_rejects, sb.empty_rejects, sb.errors);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d results outstanding", sb.awaited.size());
        $display("Verification failed");
        $finish;
    end

endmodule
